/* rtl/mpb_pkg.sv */
// Shared types and constants of the magnetic pendulum basin classifier.
`default_nettype none
package mpb_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_RADIUS    = 3'd0,
    CFG_RESTORE   = 3'd1,
    CFG_STRENGTH  = 3'd2,
    CFG_FRICTION  = 3'd3,
    CFG_TIME_STEP = 3'd4,
    CFG_ITER_LIM  = 3'd5,
    CFG_CAP_DIST  = 3'd6,
    CFG_CAP_SPEED = 3'd7
  } cfg_idx_e;

  localparam logic [30:0] RADIUS_RST    = 31'd67108864;
  localparam logic [30:0] RESTORE_RST   = 31'd33554432;
  localparam logic [30:0] STRENGTH_RST  = 31'd33554432;
  localparam logic [30:0] FRICTION_RST  = 31'd13421773;
  localparam logic [30:0] TIME_STEP_RST = 31'd1342177;
  localparam logic [15:0] ITER_LIM_RST  = 16'd8000;
  localparam logic [30:0] CAP_DIST_RST  = 31'd6710886;
  localparam logic [30:0] CAP_SPEED_RST = 31'd335544;

  // sqrt(3)/2 in unsigned Q0.26
  localparam logic [25:0] HALF_SQRT3 = 26'd58117981;
  // pull only applies when floor(sqrt(ss)) > 67, i.e. ss >= 68*68
  localparam logic [63:0] MIN_PULL_SS = 64'd4624;
  // escape when floor(sqrt(ss)) > 5.0, i.e. ss >= (5*2^26 + 1)^2
  localparam logic [63:0] ESCAPE_SS = 64'd335544321 * 64'd335544321;

  typedef struct packed {
    logic [30:0] radius;
    logic [30:0] restore;
    logic [30:0] strength;
    logic [30:0] friction;
    logic [30:0] time_step;
    logic [15:0] iter_lim;
    logic [30:0] cap_dist;
    logic [30:0] cap_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } item_t;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
  } color_t;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_e;

  typedef struct packed {
    logic        start;
    iter_op_e    op;
    logic [63:0] a;
    logic [39:0] b;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } iter_rsp_t;

  // Clamp a 33-bit difference to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/mpb_if.sv */
// Valid/ready channel interfaces for start points and colors.
`default_nettype none
interface mpb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  modport source (output valid, output start_x, output start_y, input ready);
  modport sink (input valid, input start_x, input start_y, output ready);
endinterface

interface mpb_out_if;
  logic valid;
  logic ready;
  logic red;
  logic green;
  logic blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

/* rtl/mpb_front.sv */
// Front end: takes start points, clamps them to coordinate width, feeds the queue.
`default_nettype none
module mpb_front import mpb_pkg::*; #(
  parameter int CW = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic signed [31:0] in_x_i,
  input  wire logic signed [31:0] in_y_i,
  output      logic               push_o,
  output      item_t              data_o,
  input  wire logic               full_i
);

  localparam logic signed [31:0] S_HI = 32'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [31:0] S_LO = -S_HI - 32'sd1;

  logic  hv_q, hv_d;
  item_t item_q;

  function automatic logic signed [31:0] sat_cw(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > S_HI) begin
      r = S_HI;
    end else if (v < S_LO) begin
      r = S_LO;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign in_ready_o = !hv_q || !full_i;
  assign push_o     = hv_q && !full_i;
  assign data_o     = item_q;

  // holding register valid
  always_comb begin
    hv_d = hv_q;
    if (in_valid_i && in_ready_o) begin
      hv_d = 1'b1;
    end else if (push_o) begin
      hv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
    end else begin
      hv_q <= hv_d;
    end
  end

  // clamped payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.x <= sat_cw(in_x_i);
      item_q.y <= sat_cw(in_y_i);
    end
  end

endmodule
`default_nettype wire

/* rtl/mpb_fifo.sv */
// Two-entry queue between front end and integrator.
`default_nettype none
module mpb_fifo import mpb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t data_i,
  output      logic  full_o,
  input  wire logic  pop_i,
  output      logic  empty_o,
  output      item_t data_o
);

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

/* rtl/mpb_iter.sv */
// Shared bit-serial unit: 64-bit integer square root or 64/40 divide, 32 result bits.
`default_nettype none
module mpb_iter import mpb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire iter_req_t req_i,
  output      iter_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  iter_op_e    op_q;
  logic [40:0] rem_q;
  logic [63:0] opd_q;
  logic [39:0] div_q;
  logic [31:0] res_q;

  logic [40:0] trial_x, cmp_x, diff_x;
  logic        take_x;

  // one compare-subtract per cycle
  always_comb begin
    if (op_q == OP_DIV) begin
      trial_x = {rem_q[39:0], opd_q[63]};
      cmp_x   = {1'b0, div_q};
    end else begin
      trial_x = {rem_q[38:0], opd_q[63:62]};
      cmp_x   = {7'b0, res_q, 2'b01};
    end
    take_x = trial_x >= cmp_x;
    diff_x = trial_x - cmp_x;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      div_q <= req_i.b;
      res_q <= 32'd0;
      if (req_i.op == OP_DIV) begin
        rem_q <= {9'd0, req_i.a[63:32]};
        opd_q <= {req_i.a[31:0], 32'd0};
      end else begin
        rem_q <= 41'd0;
        opd_q <= req_i.a;
      end
    end else if (busy_q) begin
      rem_q <= take_x ? diff_x : trial_x;
      res_q <= {res_q[30:0], take_x};
      opd_q <= (op_q == OP_DIV) ? {opd_q[62:0], 1'b0} : {opd_q[61:0], 2'b00};
    end
  end

endmodule
`default_nettype wire

/* rtl/mpb_engine.sv */
// Back end: Euler integration of the bob, capture and escape tests, color decision.
`default_nettype none
module mpb_engine import mpb_pkg::*; #(
  parameter int CW = 32,
  parameter int LW = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      item_valid_i,
  input  wire item_t     item_i,
  output      logic      item_pop_o,
  output      iter_req_t req_o,
  input  wire iter_rsp_t rsp_i,
  output      logic      res_valid_o,
  input  wire logic      res_ready_i,
  output      color_t    res_o
);

  localparam logic [39:0] W_HI_U = 40'((64'd1 << (CW - 1)) - 64'd1);

  typedef enum logic [5:0] {
    ST_IDLE, ST_INIT_MX, ST_INIT_CS, ST_INIT_CD, ST_INIT_END, ST_CHECK,
    ST_SPD_A, ST_SPD_B, ST_SPD_C, ST_CAP_A, ST_CAP_B, ST_CAP_C,
    ST_RST_X, ST_RST_Y, ST_RST_END,
    ST_PULL_SEL, ST_PULL_SQ, ST_PULL_M, ST_PULL_MX, ST_PULL_DX, ST_PULL_QX,
    ST_PULL_MY, ST_PULL_DY, ST_PULL_QY,
    ST_FRIC_X, ST_FRIC_Y, ST_FRIC_END, ST_VEL_X, ST_VEL_Y, ST_VEL_END,
    ST_POS_X, ST_POS_Y, ST_POS_END, ST_ESC_A, ST_ESC_B, ST_ESC_C,
    ST_NEAR_A, ST_NEAR_B, ST_NEAR_C, ST_DONE
  } state_e;

  state_e                 state_q;
  logic signed [CW-1:0]   px_q, py_q, vx_q, vy_q;
  logic [30:0]            mx_q;
  logic [61:0]            cs2_q, cd2_q;
  logic [63:0]            sq_q, best_q;
  logic [63:0]            ss_q [3];
  logic signed [39:0]     fx_q, fy_q;
  logic [31:0]            m_q, d_q;
  logic [1:0]             j_q, chosen_q;
  logic [LW-1:0]          it_q, limit_q;
  logic                   slow_q;
  logic signed [65:0]     prod_q;
  logic                   ov_q;
  color_t                 color_q;

  logic signed [32:0]     mul_a, mul_b;
  logic signed [31:0]     magx_c, magy_c, dx_c, dy_c;
  logic signed [32:0]     dxa_c, dya_c;
  logic signed [39:0]     sh_c;
  logic [63:0]            ss_c;
  logic [63:0]            ssj_c;
  logic signed [39:0]     q_c;

  function automatic logic signed [CW-1:0] sat_w(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    logic signed [39:0] r;
    hi = $signed(W_HI_U);
    lo = -hi - 40'sd1;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[CW-1:0];
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [CW-1:0] v);
    return $signed({{(33 - CW){v[CW-1]}}, v});
  endfunction

  function automatic logic signed [39:0] sx40(input logic signed [CW-1:0] v);
    return $signed({{(40 - CW){v[CW-1]}}, v});
  endfunction

  // magnet selected by j and direction from bob to it
  always_comb begin
    case (j_q)
      2'd1: begin
        magx_c = -$signed({1'b0, mx_q});
        magy_c = -$signed({2'b00, cfg_i.radius[30:1]});
      end
      2'd2: begin
        magx_c = $signed({1'b0, mx_q});
        magy_c = -$signed({2'b00, cfg_i.radius[30:1]});
      end
      default: begin
        magx_c = 32'sd0;
        magy_c = $signed({1'b0, cfg_i.radius});
      end
    endcase
    dx_c  = sat32($signed({magx_c[31], magx_c}) - sx33(px_q));
    dy_c  = sat32($signed({magy_c[31], magy_c}) - sx33(py_q));
    dxa_c = dx_c[31] ? -$signed({dx_c[31], dx_c}) : $signed({dx_c[31], dx_c});
    dya_c = dy_c[31] ? -$signed({dy_c[31], dy_c}) : $signed({dy_c[31], dy_c});
    sh_c  = $signed(prod_q[65:26]);
    ss_c  = sq_q + prod_q[63:0];
    ssj_c = ss_q[j_q];
    q_c   = $signed({8'd0, rsp_i.res});
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (state_q)
      ST_INIT_MX: begin
        mul_a = $signed({2'b00, cfg_i.radius});
        mul_b = $signed({7'd0, HALF_SQRT3});
      end
      ST_INIT_CS: begin
        mul_a = $signed({2'b00, cfg_i.cap_speed});
        mul_b = $signed({2'b00, cfg_i.cap_speed});
      end
      ST_INIT_CD: begin
        mul_a = $signed({2'b00, cfg_i.cap_dist});
        mul_b = $signed({2'b00, cfg_i.cap_dist});
      end
      ST_SPD_A: begin mul_a = sx33(vx_q); mul_b = sx33(vx_q); end
      ST_SPD_B: begin mul_a = sx33(vy_q); mul_b = sx33(vy_q); end
      ST_CAP_A, ST_NEAR_A: begin
        mul_a = $signed({dx_c[31], dx_c});
        mul_b = $signed({dx_c[31], dx_c});
      end
      ST_CAP_B, ST_NEAR_B: begin
        mul_a = $signed({dy_c[31], dy_c});
        mul_b = $signed({dy_c[31], dy_c});
      end
      ST_RST_X: begin mul_a = $signed({2'b00, cfg_i.restore}); mul_b = sx33(px_q); end
      ST_RST_Y: begin mul_a = $signed({2'b00, cfg_i.restore}); mul_b = sx33(py_q); end
      ST_PULL_MX: begin mul_a = $signed({1'b0, m_q}); mul_b = dxa_c; end
      ST_PULL_MY: begin mul_a = $signed({1'b0, m_q}); mul_b = dya_c; end
      ST_FRIC_X: begin mul_a = $signed({2'b00, cfg_i.friction}); mul_b = sx33(vx_q); end
      ST_FRIC_Y: begin mul_a = $signed({2'b00, cfg_i.friction}); mul_b = sx33(vy_q); end
      ST_VEL_X: begin mul_a = sx33(sat_w(fx_q)); mul_b = $signed({2'b00, cfg_i.time_step}); end
      ST_VEL_Y: begin mul_a = sx33(sat_w(fy_q)); mul_b = $signed({2'b00, cfg_i.time_step}); end
      ST_POS_X: begin mul_a = sx33(vx_q); mul_b = $signed({2'b00, cfg_i.time_step}); end
      ST_POS_Y: begin mul_a = sx33(vy_q); mul_b = $signed({2'b00, cfg_i.time_step}); end
      ST_ESC_A: begin mul_a = sx33(px_q); mul_b = sx33(px_q); end
      ST_ESC_B: begin mul_a = sx33(py_q); mul_b = sx33(py_q); end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // requests to the root/divide unit
  always_comb begin
    req_o.start = 1'b0;
    req_o.op    = OP_SQRT;
    req_o.a     = ssj_c;
    req_o.b     = 40'd0;
    case (state_q)
      ST_PULL_SEL: begin
        req_o.start = ssj_c >= MIN_PULL_SS;
      end
      ST_PULL_SQ: begin
        req_o.start = rsp_i.done;
        req_o.op    = OP_DIV;
        req_o.a     = {7'd0, cfg_i.strength, 26'd0};
        req_o.b     = 40'd67108864 + {2'b00, ssj_c[63:26]};
      end
      ST_PULL_DX, ST_PULL_DY: begin
        req_o.start = 1'b1;
        req_o.op    = OP_DIV;
        req_o.a     = prod_q[63:0];
        req_o.b     = {8'd0, d_q};
      end
      default: begin
        req_o.start = 1'b0;
      end
    endcase
  end

  assign item_pop_o  = (state_q == ST_IDLE) && item_valid_i;
  assign res_valid_o = ov_q;
  assign res_o       = color_q;

  // sequencer with registered datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && (!ov_q || res_ready_i)) begin
        ov_q <= 1'b1;
      end else if (ov_q && res_ready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            px_q    <= item_i.x[CW-1:0];
            py_q    <= item_i.y[CW-1:0];
            vx_q    <= '0;
            vy_q    <= '0;
            it_q    <= '0;
            limit_q <= cfg_i.iter_lim[LW-1:0];
            state_q <= ST_INIT_MX;
          end
        end
        ST_INIT_MX: state_q <= ST_INIT_CS;
        ST_INIT_CS: begin
          mx_q    <= prod_q[56:26];
          state_q <= ST_INIT_CD;
        end
        ST_INIT_CD: begin
          cs2_q   <= prod_q[61:0];
          state_q <= ST_INIT_END;
        end
        ST_INIT_END: begin
          cd2_q   <= prod_q[61:0];
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          j_q <= 2'd0;
          if (it_q == limit_q) begin
            state_q <= ST_NEAR_A;
          end else begin
            state_q <= ST_SPD_A;
          end
        end
        ST_SPD_A: state_q <= ST_SPD_B;
        ST_SPD_B: begin
          sq_q    <= prod_q[63:0];
          state_q <= ST_SPD_C;
        end
        ST_SPD_C: begin
          slow_q  <= ss_c < {2'b00, cs2_q};
          state_q <= ST_CAP_A;
        end
        // capture test, magnets in order
        ST_CAP_A: state_q <= ST_CAP_B;
        ST_CAP_B: begin
          sq_q    <= prod_q[63:0];
          state_q <= ST_CAP_C;
        end
        ST_CAP_C: begin
          ss_q[j_q] <= ss_c;
          if (slow_q && (ss_c < {2'b00, cd2_q})) begin
            chosen_q <= j_q;
            state_q  <= ST_DONE;
          end else if (j_q == 2'd2) begin
            state_q <= ST_RST_X;
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= ST_CAP_A;
          end
        end
        // restoring force
        ST_RST_X: state_q <= ST_RST_Y;
        ST_RST_Y: begin
          fx_q    <= -sh_c;
          state_q <= ST_RST_END;
        end
        ST_RST_END: begin
          fy_q    <= -sh_c;
          j_q     <= 2'd0;
          state_q <= ST_PULL_SEL;
        end
        // magnet pulls
        ST_PULL_SEL: begin
          if (ssj_c >= MIN_PULL_SS) begin
            state_q <= ST_PULL_SQ;
          end else if (j_q == 2'd2) begin
            state_q <= ST_FRIC_X;
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        ST_PULL_SQ: begin
          if (rsp_i.done) begin
            d_q     <= rsp_i.res;
            state_q <= ST_PULL_M;
          end
        end
        ST_PULL_M: begin
          if (rsp_i.done) begin
            m_q     <= rsp_i.res;
            state_q <= ST_PULL_MX;
          end
        end
        ST_PULL_MX: state_q <= ST_PULL_DX;
        ST_PULL_DX: state_q <= ST_PULL_QX;
        ST_PULL_QX: begin
          if (rsp_i.done) begin
            fx_q    <= dx_c[31] ? fx_q - q_c : fx_q + q_c;
            state_q <= ST_PULL_MY;
          end
        end
        ST_PULL_MY: state_q <= ST_PULL_DY;
        ST_PULL_DY: state_q <= ST_PULL_QY;
        ST_PULL_QY: begin
          if (rsp_i.done) begin
            fy_q <= dy_c[31] ? fy_q - q_c : fy_q + q_c;
            if (j_q == 2'd2) begin
              state_q <= ST_FRIC_X;
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= ST_PULL_SEL;
            end
          end
        end
        // friction
        ST_FRIC_X: state_q <= ST_FRIC_Y;
        ST_FRIC_Y: begin
          fx_q    <= fx_q - sh_c;
          state_q <= ST_FRIC_END;
        end
        ST_FRIC_END: begin
          fy_q    <= fy_q - sh_c;
          state_q <= ST_VEL_X;
        end
        // velocity then position update
        ST_VEL_X: state_q <= ST_VEL_Y;
        ST_VEL_Y: begin
          vx_q    <= sat_w(sx40(vx_q) + sh_c);
          state_q <= ST_VEL_END;
        end
        ST_VEL_END: begin
          vy_q    <= sat_w(sx40(vy_q) + sh_c);
          state_q <= ST_POS_X;
        end
        ST_POS_X: state_q <= ST_POS_Y;
        ST_POS_Y: begin
          px_q    <= sat_w(sx40(px_q) + sh_c);
          state_q <= ST_POS_END;
        end
        ST_POS_END: begin
          py_q    <= sat_w(sx40(py_q) + sh_c);
          state_q <= ST_ESC_A;
        end
        // escape test
        ST_ESC_A: state_q <= ST_ESC_B;
        ST_ESC_B: begin
          sq_q    <= prod_q[63:0];
          state_q <= ST_ESC_C;
        end
        ST_ESC_C: begin
          it_q <= it_q + 1'b1;
          j_q  <= 2'd0;
          if (ss_c >= ESCAPE_SS) begin
            state_q <= ST_NEAR_A;
          end else begin
            state_q <= ST_CHECK;
          end
        end
        // nearest magnet, earlier one wins a tie
        ST_NEAR_A: state_q <= ST_NEAR_B;
        ST_NEAR_B: begin
          sq_q    <= prod_q[63:0];
          state_q <= ST_NEAR_C;
        end
        ST_NEAR_C: begin
          if ((j_q == 2'd0) || (ss_c < best_q)) begin
            best_q   <= ss_c;
            chosen_q <= j_q;
          end
          if (j_q == 2'd2) begin
            state_q <= ST_DONE;
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= ST_NEAR_A;
          end
        end
        // load the output register once it is free
        ST_DONE: begin
          if (!ov_q || res_ready_i) begin
            color_q.red   <= chosen_q == 2'd0;
            color_q.green <= chosen_q == 2'd1;
            color_q.blue  <= chosen_q == 2'd2;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/magnetic_pendulum_basin_core.sv */
// Top level of the magnetic pendulum basin classifier: config registers and wiring.
//
//   channel  dir  payload                    transfer
//   in_i     in   start_x, start_y (Q5.26)   valid && ready
//   out_o    out  red, green, blue           valid && ready
//   cfg      in   cfg_idx_i, cfg_data_i      cfg_we_i
//
// One point runs up to iteration_limit Euler steps; each step uses the shared root/divide
// unit for up to three roots and nine divides and sequences its other arithmetic through
// the shared 33x33 multiplier.
// Reset loads the config defaults and empties the two-entry point queue; no clearing pass.
// The front end keeps accepting points until the queue is full; a result waits in
// the output register while the next point is integrated.
`default_nettype none
module magnetic_pendulum_basin_core import mpb_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int ITER_WIDTH  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_data_i,
  mpb_in_if.sink           in_i,
  mpb_out_if.source        out_o
);

  localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int LW = (ITER_WIDTH < 16) ? ITER_WIDTH : 16;

  cfg_t      cfg_q;
  logic      push, full, empty, pop;
  item_t     push_data, pop_data;
  iter_req_t req;
  iter_rsp_t rsp;
  color_t    color;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius    <= RADIUS_RST;
      cfg_q.restore   <= RESTORE_RST;
      cfg_q.strength  <= STRENGTH_RST;
      cfg_q.friction  <= FRICTION_RST;
      cfg_q.time_step <= TIME_STEP_RST;
      cfg_q.iter_lim  <= ITER_LIM_RST;
      cfg_q.cap_dist  <= CAP_DIST_RST;
      cfg_q.cap_speed <= CAP_SPEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIUS:    cfg_q.radius    <= cfg_data_i;
        CFG_RESTORE:   cfg_q.restore   <= cfg_data_i;
        CFG_STRENGTH:  cfg_q.strength  <= cfg_data_i;
        CFG_FRICTION:  cfg_q.friction  <= cfg_data_i;
        CFG_TIME_STEP: cfg_q.time_step <= cfg_data_i;
        CFG_ITER_LIM:  cfg_q.iter_lim  <= cfg_data_i[15:0];
        CFG_CAP_DIST:  cfg_q.cap_dist  <= cfg_data_i;
        CFG_CAP_SPEED: cfg_q.cap_speed <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mpb_front #(.CW(CW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_x_i     (in_i.start_x),
    .in_y_i     (in_i.start_y),
    .push_o     (push),
    .data_o     (push_data),
    .full_i     (full)
  );

  mpb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  mpb_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  mpb_engine #(.CW(CW), .LW(LW)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (!empty),
    .item_i       (pop_data),
    .item_pop_o   (pop),
    .req_o        (req),
    .rsp_i        (rsp),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_o        (color)
  );

  assign out_o.red   = color.red;
  assign out_o.green = color.green;
  assign out_o.blue  = color.blue;

endmodule
`default_nettype wire
